// ===== sv/bsd_pkg.sv =====
// Shared constants and types for the Bayer 2x2 binning debayer.
package bsd_pkg;

  localparam int unsigned LINE_WIDTH = 640;
  localparam int unsigned HALF_WIDTH = LINE_WIDTH / 2;
  localparam int unsigned COL_W      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
  localparam int unsigned CELL_W     = (HALF_WIDTH > 1) ? $clog2(HALF_WIDTH) : 1;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_WIDTH - 1);

  // Per-transaction line store control from the position tracker.
  typedef struct packed {
    logic              red_en;  // latch red sample (even row, even column)
    logic              wr_en;   // write red/green pair (even row, odd column)
    logic              rd_en;   // read pair for output (odd row, odd column)
    logic [CELL_W-1:0] slot;    // store entry of this 2x2 cell
  } store_ctl_t;

endpackage

// ===== sv/bayer_superpixel_debayer.sv =====
// Top level of the RGGB Bayer 2x2 binning debayer stream block.
//
//  channel | direction | tdata                               | tuser
//  s_axis  | in        | [7:0] raw_sample                    | [0] frame_start
//  m_axis  | out       | [7:0] red, [15:8] green, [23:16] blue | -
//
// One raw sample per cycle is accepted while input ready is high; results pass
// through the line store read register, then the output register.
// One RGB pixel leaves for every odd-row, odd-column sample; other samples
// give no result.
// Reset clears position, pending red and valid flags; the half-line store is
// not cleared and needs no clearing pass.
// A stalled output holds the pipeline; input ready stays high while the read
// stage is empty or moving on.
module bayer_superpixel_debayer import bsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_sample
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

  logic       accept;
  logic       s1_adv;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_blue_q;
  logic       out_valid_q, out_valid_d;
  logic [23:0] out_data_q;
  logic [15:0] rd_data;
  store_ctl_t ctl;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bsd_position u_position (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (s_axis_tuser),
    .ctl_o         (ctl)
  );

  bsd_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sample_i  (s_axis_tdata),
    .rd_data_o (rd_data)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (ctl.rd_en) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.rd_en) begin
      s1_blue_q <= s_axis_tdata;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= {s1_blue_q, rd_data[7:0], rd_data[15:8]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("input stalled with empty read stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_blue_q) && $stable(rd_data))
    else $error("stalled read stage lost its pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv |=> out_valid_q)
    else $error("pixel leaving read stage not captured in output register");

endmodule

// ===== sv/bsd_position.sv =====
// Column and row parity tracker; decodes line store actions per sample.
module bsd_position import bsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       frame_start_i,
  output store_ctl_t ctl_o
);

  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic             odd_q, odd_d, odd_cur;

  // Frame start restarts the position before this sample is handled.
  assign col_cur = frame_start_i ? '0 : col_q;
  assign odd_cur = frame_start_i ? 1'b0 : odd_q;

  always_comb begin
    ctl_o.red_en = accept_i && !odd_cur && !col_cur[0];
    ctl_o.wr_en  = accept_i && !odd_cur && col_cur[0];
    ctl_o.rd_en  = accept_i && odd_cur && col_cur[0];
    ctl_o.slot   = CELL_W'(col_cur >> 1);
  end

  always_comb begin
    col_d = col_q;
    odd_d = odd_q;
    if (accept_i) begin
      if (col_cur == LAST_COL) begin
        col_d = '0;
        odd_d = !odd_cur;
      end else begin
        col_d = col_cur + COL_W'(1);
        odd_d = odd_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      odd_q <= 1'b0;
    end else begin
      col_q <= col_d;
      odd_q <= odd_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LAST_COL)
    else $error("column position beyond line width");

endmodule

// ===== sv/bsd_line_store.sv =====
// Pending red register and half-line store of red/green pairs.
module bsd_line_store import bsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  store_ctl_t  ctl_i,
  input  logic [7:0]  sample_i,
  output logic [15:0] rd_data_o
);

  logic [15:0] mem [HALF_WIDTH];
  logic [7:0]  red_q;
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= '0;
    end else if (ctl_i.red_en) begin
      red_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.slot] <= {red_q, sample_i};
    end
  end

  // Hold read data until the next read so a stalled pipeline keeps it.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[ctl_i.slot];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
